/* rtl/lil_pkg.sv */
// lil_pkg: shared constants, request/status codes and the command struct
// for the indexed insert/delete list. No dependencies.
`timescale 1ns / 1ps

package lil_pkg;

  localparam int CAPACITY = 1024;                       // list size, 2 to 2047
  localparam int IDX_W    = $clog2(CAPACITY);           // cell index width
  localparam int CNT_W    = $clog2(CAPACITY + 1);       // element count width
  localparam int POS_W    = 11;                         // position field width
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_POS  = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             load_rd;
    logic [IDX_W-1:0] pidx;
    logic [7:0]       val;
  } cmd_t;

endpackage

/* rtl/lil_cell.sv */
// lil_cell: one list slot. Holds a byte and a read-return byte, both fed
// from its neighbors. Depends on lil_pkg.
`timescale 1ns / 1ps

module lil_cell (
  input  logic                      clk,
  input  lil_pkg::cmd_t             cmd,
  input  logic [lil_pkg::IDX_W-1:0] cell_idx,
  input  logic [7:0]                left_data,
  input  logic [7:0]                right_data,
  input  logic [7:0]                right_rd,
  output logic [7:0]                data_q,
  output logic [7:0]                rd_q
);

  logic [7:0] data_r, data_nxt;
  logic [7:0] rd_r, rd_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (cell_idx > cmd.pidx) begin
        data_nxt = left_data;
      end else if (cell_idx == cmd.pidx) begin
        data_nxt = cmd.val;
      end
    end else if (cmd.shift_down) begin
      if (cell_idx >= cmd.pidx) begin
        data_nxt = right_data;
      end
    end
  end

  // read data walks toward cell 0 one slot per cycle
  always_comb begin
    rd_nxt = right_rd;
    if (cmd.load_rd && (cell_idx == cmd.pidx)) begin
      rd_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data_q = data_r;
  assign rd_q   = rd_r;

endmodule

/* rtl/lil_ctrl.sv */
// lil_ctrl: request decode, element count, read wait sequencer and result
// registers. Drives the cell command. Depends on lil_pkg.
`timescale 1ns / 1ps

module lil_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [lil_pkg::POS_W-1:0]   in_position,
  input  logic [7:0]                  in_item_value,
  input  logic [7:0]                  rd_head,
  output lil_pkg::cmd_t               cmd,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [7:0]                  out_read_value,
  output logic [10:0]                 out_element_count
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                    state_r;
  logic [lil_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [lil_pkg::IDX_W-1:0] wait_r;
  logic                      valid_r;
  logic [1:0]                status_r, status_nxt;
  logic [7:0]                rdval_r;

  logic                      accept;
  logic [lil_pkg::CMP_W-1:0] pos_x, cnt_x;
  logic                      full, ins_ok, sel_ok, rd_go;

  assign accept = start && (state_r == S_IDLE);
  assign pos_x  = lil_pkg::CMP_W'(in_position);
  assign cnt_x  = lil_pkg::CMP_W'(count_r);
  assign full   = (count_r == lil_pkg::CNT_W'(lil_pkg::CAPACITY));
  assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + lil_pkg::CMP_W'(1));
  assign sel_ok = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    cmd            = '0;
    cmd.pidx       = lil_pkg::IDX_W'(in_position - lil_pkg::POS_W'(1));
    cmd.val        = in_item_value;
    count_nxt      = count_r;
    status_nxt     = lil_pkg::ST_OK;
    rd_go          = 1'b0;
    unique case (lil_pkg::req_t'(in_req_type))
      lil_pkg::REQ_INSERT: begin
        if (full) begin
          status_nxt = lil_pkg::ST_OVERFLOW;
        end else if (!ins_ok) begin
          status_nxt = lil_pkg::ST_BAD_POS;
        end else begin
          cmd.shift_up = accept;
          count_nxt    = count_r + lil_pkg::CNT_W'(1);
        end
      end
      lil_pkg::REQ_DELETE: begin
        if (!sel_ok) begin
          status_nxt = lil_pkg::ST_BAD_POS;
        end else begin
          cmd.shift_down = accept;
          count_nxt      = count_r - lil_pkg::CNT_W'(1);
        end
      end
      lil_pkg::REQ_READ: begin
        if (!sel_ok) begin
          status_nxt = lil_pkg::ST_BAD_POS;
        end else begin
          cmd.load_rd = accept;
          rd_go       = 1'b1;
        end
      end
      lil_pkg::REQ_NONE: begin
        status_nxt = lil_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r <= count_nxt;
            if (rd_go) begin
              state_r <= S_READ;
              wait_r  <= cmd.pidx;
            end else begin
              valid_r  <= 1'b1;
              status_r <= status_nxt;
              rdval_r  <= 8'd0;
            end
          end
        end
        S_READ: begin
          if (wait_r == '0) begin
            state_r  <= S_IDLE;
            valid_r  <= 1'b1;
            status_r <= lil_pkg::ST_OK;
            rdval_r  <= rd_head;
          end else begin
            wait_r <= wait_r - lil_pkg::IDX_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_read_value    = rdval_r;
  assign out_element_count = 11'(count_r);

endmodule

/* rtl/indexed_insert_delete_list_top.sv */
// indexed_insert_delete_list_top: ordered byte list built as a chain of
// cells plus a controller. Depends on lil_pkg, lil_cell, lil_ctrl.
`timescale 1ns / 1ps

// Usage
//   Requests: drive in_req_type (0 insert, 1 delete, 2 read), in_position
//   (1-based) and in_item_value with start high; the transfer happens at
//   the rising edge where start is high and busy is low.
//   Results: one per request, shown for one cycle with out_valid high:
//   out_status (0 ok, 1 list full, 2 bad position), out_read_value and
//   out_element_count (count after the request). The receiver cannot stall;
//   a result is gone after its cycle.
//   Insert, delete, bad or unused requests strobe the cycle after the
//   transfer and busy stays low, so one request per cycle is sustained.
//   A successful read at position p walks the byte down the read-return
//   chain of the cells, one cell per cycle, and busy is high until the
//   result strobes.
//   Insert and delete move every affected element together: each cell
//   compares its own index with the position and loads from a neighbor.
//   Reset (rst_n low, synchronous) empties the list; cell contents are not
//   cleared since slots beyond the count are never read.
module indexed_insert_delete_list_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [10:0] in_position,
  input  logic [7:0]  in_item_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_value,
  output logic [10:0] out_element_count
);

  lil_pkg::cmd_t cmd;
  logic [7:0]    data_w [lil_pkg::CAPACITY];
  logic [7:0]    rd_w   [lil_pkg::CAPACITY];

  lil_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .rd_head           (rd_w[0]),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

  // Cell i holds position i+1. Ends loop back to themselves (unused at cell 0;
  // a delete reloads the last cell's byte) and the read chain is fed zero at the far end.
  for (genvar i = 0; i < lil_pkg::CAPACITY; i++) begin : g_cell
    logic [7:0] left_d, right_d, right_r;
    if (i == 0) begin : g_first
      assign left_d = data_w[i];
    end else begin : g_mid_l
      assign left_d = data_w[i-1];
    end
    if (i == lil_pkg::CAPACITY - 1) begin : g_last
      assign right_d = data_w[i];
      assign right_r = 8'd0;
    end else begin : g_mid_r
      assign right_d = data_w[i+1];
      assign right_r = rd_w[i+1];
    end

    lil_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (lil_pkg::IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .right_rd   (right_r),
      .data_q     (data_w[i]),
      .rd_q       (rd_w[i])
    );
  end

endmodule

/* rtl/lil_checker.sv */
// lil_checker: port-level assertions for indexed_insert_delete_list_top,
// bound to the top level. Depends on lil_pkg.
`timescale 1ns / 1ps

module lil_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [7:0]  out_read_value
);

  // non-read transfers answer on the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type != lil_pkg::REQ_READ)) |=> out_valid)
    else $error("missing result after non-read transfer");

  // busy only comes up after a transfer
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a transfer");

  // a failed request never returns data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != lil_pkg::ST_OK)) |-> (out_read_value == 8'd0))
    else $error("read value on error result");

  // busy ends exactly with the read result
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != lil_pkg::ST_UNUSED))
    else $error("unused status code");

endmodule

bind indexed_insert_delete_list_top lil_checker u_lil_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_read_value (out_read_value)
);

/* tb/indexed_insert_delete_list_top_test.sv */
// Self-checking testbench for indexed_insert_delete_list_top: ordered byte
// list with positional insert, delete and read. Depends on lil_pkg and the RTL.
`timescale 1ns / 1ps

module indexed_insert_delete_list_top_test;

  // Any cycle with neither a request nor a result transfer counts as idle.
  // The slowest correct case is a read at the last of 1024 places plus a long
  // sender gap. This limit is several times that.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POS_MAX        = 2047;   // largest value of the 11-bit field

  // One result as the block should report it
  typedef struct packed {
    lil_pkg::status_t status;
    logic [7:0]       read_value;
    logic [10:0]      element_count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = 2'd0;
  logic [10:0] in_position = 11'd0;
  logic [7:0]  in_item_value = 8'd0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_read_value;
  logic [10:0] out_element_count;

  indexed_insert_delete_list_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the list. Only places 1..list_len hold written bytes.
  // ---------------------------------------------------------------------------
  logic [7:0]   list_mem [lil_pkg::CAPACITY];
  int           list_len = 0;
  list_result_t pending_results[$];   // results owed by the block, oldest first

  int err_cnt = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;              // when set, the sender never pauses

  // Coverage tallies for the summary
  int n_op[4] = '{default: 0};
  int n_overflow = 0;
  int n_bad_pos = 0;
  int n_read_ok = 0;
  int peak_len = 0;

  // Apply one request to the shadow list and return the result it must give.
  // Overflow is checked before the position, so an insert into a full list always overflows.
  function automatic list_result_t apply_list_op(lil_pkg::req_t op, int pos,
                                                 logic [7:0] val);
    list_result_t res;
    int j;
    res.status     = lil_pkg::ST_OK;
    res.read_value = 8'd0;
    case (op)
      lil_pkg::REQ_INSERT: begin
        if (list_len >= lil_pkg::CAPACITY) begin
          res.status = lil_pkg::ST_OVERFLOW;
        end else if (pos < 1 || pos > list_len + 1) begin
          res.status = lil_pkg::ST_BAD_POS;
        end else begin
          // open a hole at pos by moving the tail up one place
          for (j = list_len; j >= pos; j--) list_mem[j] = list_mem[j-1];
          list_mem[pos-1] = val;
          list_len++;
        end
      end
      lil_pkg::REQ_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          res.status = lil_pkg::ST_BAD_POS;
        end else begin
          // close the gap left at pos
          for (j = pos; j < list_len; j++) list_mem[j-1] = list_mem[j];
          list_len--;
        end
      end
      lil_pkg::REQ_READ: begin
        if (pos < 1 || pos > list_len) res.status = lil_pkg::ST_BAD_POS;
        else res.read_value = list_mem[pos-1];
      end
      default: ;   // unused code: list untouched, status ok
    endcase
    res.element_count = 11'(list_len);
    return res;
  endfunction

  // Sender gap: mostly none or short, now and then long; none in burst mode.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Send one request. Called at a rising edge; returns at the edge that took
  // the transfer, or after the gap that follows it. start stays high between
  // back-to-back requests so it is never dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic issue_request(lil_pkg::req_t op, int pos, logic [7:0] val, int gap);
    start         <= 1'b1;
    in_req_type   <= op;
    in_position   <= 11'(pos);
    in_item_value <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_op(op, pos, val));
    n_op[op]++;
    if (list_len > peak_len) peak_len = list_len;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random valid position for a read or delete (list must not be empty).
  function automatic int any_held_pos();
    return $urandom_range(1, list_len);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with none owed: status %0d read_value %0d element_count %0d",
               out_status, out_read_value, out_element_count);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("out_status: expected %0d, got %0d", exp_res.status, out_status);
          err_cnt++;
        end
        if (out_read_value !== exp_res.read_value) begin
          $error("out_read_value: expected %0d, got %0d", exp_res.read_value,
                 out_read_value);
          err_cnt++;
        end
        if (out_element_count !== exp_res.element_count) begin
          $error("out_element_count: expected %0d, got %0d", exp_res.element_count,
                 out_element_count);
          err_cnt++;
        end
        case (exp_res.status)
          lil_pkg::ST_OVERFLOW: n_overflow++;
          lil_pkg::ST_BAD_POS:  n_bad_pos++;
          default: if (exp_res.read_value != 0 || out_read_value != 0) n_read_ok++;
        endcase
      end
    end
  end

  // Watchdog: idle counter cleared by any transfer in either direction
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed: empty-list errors, insert at front, middle and end, reads at
  // both ends, out-of-range positions, the unused request code, extreme
  // bytes and the largest position value. Back to back, no gaps.
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    issue_request(lil_pkg::REQ_READ,   1, 8'h00, 0);        // empty list
    issue_request(lil_pkg::REQ_DELETE, 1, 8'h00, 0);        // empty list
    issue_request(lil_pkg::REQ_INSERT, 0, 8'h11, 0);        // position zero
    issue_request(lil_pkg::REQ_INSERT, 2, 8'h22, 0);        // beyond count+1
    issue_request(lil_pkg::REQ_INSERT, 1, 8'h00, 0);        // first element
    issue_request(lil_pkg::REQ_INSERT, 2, 8'hFF, 0);        // append
    issue_request(lil_pkg::REQ_INSERT, 1, 8'h5A, 0);        // front
    issue_request(lil_pkg::REQ_INSERT, 2, 8'hA5, 0);        // middle -> 5A A5 00 FF
    issue_request(lil_pkg::REQ_READ,   1, 8'h00, 0);
    issue_request(lil_pkg::REQ_READ,   4, 8'h00, 0);        // last
    issue_request(lil_pkg::REQ_READ,   5, 8'h00, 0);        // past the end
    issue_request(lil_pkg::REQ_READ,   0, 8'h00, 0);
    issue_request(lil_pkg::REQ_NONE, POS_MAX, 8'hFF, 0);    // unused code
    issue_request(lil_pkg::REQ_DELETE, 0, 8'h00, 0);
    issue_request(lil_pkg::REQ_DELETE, 5, 8'h00, 0);
    issue_request(lil_pkg::REQ_DELETE, 2, 8'h00, 0);        // middle -> 5A 00 FF
    issue_request(lil_pkg::REQ_READ,   2, 8'h00, 0);
    issue_request(lil_pkg::REQ_DELETE, 3, 8'h00, 0);        // last -> 5A 00
    issue_request(lil_pkg::REQ_DELETE, 1, 8'h00, 0);        // first -> 00
    issue_request(lil_pkg::REQ_READ,   1, 8'h00, 0);
    issue_request(lil_pkg::REQ_INSERT, POS_MAX, 8'h33, 0);
    issue_request(lil_pkg::REQ_READ,   POS_MAX, 8'h00, 0);
    issue_request(lil_pkg::REQ_DELETE, 1, 8'h00, 0);        // back to empty
    issue_request(lil_pkg::REQ_NONE,   0, 8'h00, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Fill to capacity, try inserts on the full list (overflow whatever the
  // position), read the deepest place, then delete a short run.
  // ---------------------------------------------------------------------------
  task automatic test_full_list();
    int k;
    k = 0;
    while (list_len < lil_pkg::CAPACITY) begin
      issue_request(lil_pkg::REQ_INSERT, $urandom_range(1, list_len + 1),
                    8'($urandom_range(0, 255)), pick_gap());
      if (++k % 128 == 0)
        issue_request(lil_pkg::REQ_READ, any_held_pos(), 8'h00, pick_gap());
    end
    issue_request(lil_pkg::REQ_INSERT, 1, 8'hFF, 0);
    issue_request(lil_pkg::REQ_INSERT, list_len + 1, 8'h00, 0);
    issue_request(lil_pkg::REQ_INSERT, 0, 8'h77, 0);
    issue_request(lil_pkg::REQ_INSERT, POS_MAX, 8'h88, 0);
    issue_request(lil_pkg::REQ_READ, lil_pkg::CAPACITY, 8'h00, 0);  // longest walk
    issue_request(lil_pkg::REQ_READ, 1, 8'h00, 0);
    issue_request(lil_pkg::REQ_READ, lil_pkg::CAPACITY + 1, 8'h00, 0);
    issue_request(lil_pkg::REQ_DELETE, lil_pkg::CAPACITY + 1, 8'h00, 0);
    issue_request(lil_pkg::REQ_DELETE, lil_pkg::CAPACITY, 8'h00, 0); // last of full
    k = 0;
    repeat (24) begin
      issue_request(lil_pkg::REQ_DELETE, any_held_pos(), 8'h00, pick_gap());
      if (++k % 8 == 0)
        issue_request(lil_pkg::REQ_READ, any_held_pos(), 8'h00, pick_gap());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly valid requests on a list kept short (so reads stay
  // cheap), some requests just outside the valid range, some pure noise over
  // every field value. Alternating stretches with and without sender gaps.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int n_items);
    lil_pkg::req_t op;
    int            pos;
    int            r;
    for (int i = 0; i < n_items; i++) begin
      burst_mode = ((i / 25) % 3) == 1;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        op  = lil_pkg::req_t'($urandom_range(0, 3));
        pos = $urandom_range(0, POS_MAX);
      end else if (r < 18) begin
        op = lil_pkg::req_t'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0:       pos = 0;
          1:       pos = (op == lil_pkg::REQ_INSERT) ? list_len + 2 : list_len + 1;
          default: pos = list_len + 2 + $urandom_range(0, 60);
        endcase
      end else begin
        // steer the length to stay roughly between 4 and 48
        r = $urandom_range(0, 99);
        if (list_len == 0 || (list_len < 4 && r < 70)) op = lil_pkg::REQ_INSERT;
        else if (list_len > 48 && r < 70) op = lil_pkg::REQ_DELETE;
        else if (r < 40) op = lil_pkg::REQ_INSERT;
        else if (r < 70) op = lil_pkg::REQ_DELETE;
        else op = lil_pkg::REQ_READ;
        if (op == lil_pkg::REQ_INSERT) begin
          r   = $urandom_range(0, 9);
          pos = (r == 0) ? 1 : (r == 1) ? list_len + 1 : $urandom_range(1, list_len + 1);
        end else begin
          r   = $urandom_range(0, 9);
          pos = (r == 0) ? 1 : (r == 1) ? list_len : any_held_pos();
        end
      end
      issue_request(op, pos, 8'($urandom_range(0, 255)), pick_gap());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests, wait for every owed result, settle,
  // report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(100);
    test_full_list();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // room for any stray strobe
    repeat (64) @(posedge clk);

    $display("covered: %0d inserts, %0d deletes, %0d reads, %0d unused-code requests",
             n_op[lil_pkg::REQ_INSERT], n_op[lil_pkg::REQ_DELETE],
             n_op[lil_pkg::REQ_READ], n_op[lil_pkg::REQ_NONE]);
    $display("covered: %0d overflows, %0d bad positions, longest list %0d of %0d",
             n_overflow, n_bad_pos, peak_len, lil_pkg::CAPACITY);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
